/* hdl/assert_macros.svh */
// Assertion macros for the keypad debounce RTL; included by kmd_core.
// Simulation gets concurrent assertions; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(name, clk, rst_n, expr)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/kmd_pkg.sv */
// Package for the keypad matrix debounce unit: widths, reset values,
// register indexes and the sample type. No dependencies.
package kmd_pkg;

  localparam int NUM_ROWS    = 4;
  localparam int NUM_COLS    = 4;
  localparam int NUM_KEYS    = NUM_ROWS * NUM_COLS;
  localparam int ROW_WIDTH   = $clog2(NUM_ROWS);
  localparam int COUNT_WIDTH = 8;
  localparam int CFG_WIDTH   = 8;
  localparam int IDLE_WIDTH  = 8;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam int CFG_INDEX_WIDTH = 1;

  typedef logic [ROW_WIDTH-1:0]   row_t;
  typedef logic [NUM_COLS-1:0]    col_t;
  typedef logic [NUM_KEYS-1:0]    key_vec_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CFG_WIDTH-1:0]   cfg_t;
  typedef logic [IDLE_WIDTH-1:0]  idle_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_PRESS_THRESHOLD = 1'b0,
    CFG_IDLE_LIMIT      = 1'b1
  } cfg_idx_e;

  localparam cfg_t PRESS_THRESHOLD_RST = CFG_WIDTH'(20);
  localparam cfg_t IDLE_LIMIT_RST      = CFG_WIDTH'(40);
  localparam col_t COLS_IDLE           = '1;

  typedef struct packed {
    row_t row;
    col_t cols;
  } sample_t;

endpackage

/* hdl/kmd_in_reg.sv */
// Input register of the keypad debounce unit: holds one row sample.
// Depends on kmd_pkg.
module kmd_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  kmd_pkg::sample_t sample_i,
  input  logic             advance_i,
  output logic             valid_o,
  output kmd_pkg::sample_t sample_o
);
  import kmd_pkg::*;

  logic    valid_q, valid_d;
  sample_t sample_q;
  logic    load;

  assign ready_o = !valid_q || advance_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= sample_i;
    end
  end

  assign valid_o  = valid_q;
  assign sample_o = sample_q;

endmodule

/* hdl/kmd_core.sv */
// Debounce state of the keypad unit: per-key press counters, key states
// and the idle counter, updated once per row sample. Depends on kmd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kmd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  kmd_pkg::sample_t  sample_i,
  input  kmd_pkg::cfg_t     press_threshold_i,
  input  kmd_pkg::cfg_t     idle_limit_i,
  output kmd_pkg::key_vec_t key_vec_o
);
  import kmd_pkg::*;

  count_t   cnt_q [NUM_KEYS];
  count_t   cnt_d [NUM_KEYS];
  key_vec_t key_states_q, key_states_d;
  idle_t    idle_count_q, idle_count_d;

  logic     idle_row;
  logic     idle_clear;
  idle_t    idle_inc;
  key_vec_t hit;
  key_vec_t release_mask;
  key_vec_t winner;

  assign idle_row   = (sample_i.cols == COLS_IDLE);
  assign idle_inc   = idle_count_q + IDLE_WIDTH'(1);
  assign idle_clear = (idle_inc >= IDLE_WIDTH'(idle_limit_i));

  // Each key is a cell of its own; on a non-idle sample only the row's four keys move.
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      logic   sel;
      logic   col_high;
      count_t inc;
      sel      = !idle_row && (sample_i.row == ROW_WIDTH'(k / NUM_COLS));
      col_high = sample_i.cols[NUM_COLS - 1 - (k % NUM_COLS)];
      inc      = (cnt_q[k] == '1) ? cnt_q[k] : cnt_q[k] + COUNT_WIDTH'(1);
      hit[k]          = sel && !col_high &&
                        (CMP_WIDTH'(inc) > CMP_WIDTH'(press_threshold_i));
      release_mask[k] = sel && col_high;
      if (idle_row) begin
        cnt_d[k] = idle_clear ? '0 : cnt_q[k];
      end else if (sel) begin
        cnt_d[k] = col_high ? '0 : inc;
      end else begin
        cnt_d[k] = cnt_q[k];
      end
    end
  end

  // The highest column of the row wins, which is its lowest key number.
  assign winner = hit & (~hit + NUM_KEYS'(1));

  always_comb begin
    idle_count_d = idle_count_q;
    if (idle_row) begin
      idle_count_d = idle_clear ? '0 : idle_inc;
      key_states_d = idle_clear ? '0 : key_states_q;
    end else if (hit != '0) begin
      key_states_d = winner;
    end else begin
      key_states_d = key_states_q & ~release_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_states_q <= '0;
      idle_count_q <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (fire_i) begin
      key_states_q <= key_states_d;
      idle_count_q <= idle_count_d;
      for (int k = 0; k < NUM_KEYS; k++) begin
        cnt_q[k] <= cnt_d[k];
      end
    end
  end

  assign key_vec_o = key_states_d;

  `ASSERT_ALWAYS(a_onehot_state, clk_i, rst_ni, $onehot0(key_states_q))
  `ASSERT_NEXT(a_hold_state, clk_i, rst_ni, !fire_i, $stable(key_states_q) && $stable(idle_count_q))
  `ASSERT_NEXT(a_idle_clear, clk_i, rst_ni, fire_i && idle_row && idle_clear, key_states_q == '0 && idle_count_q == '0 && cnt_q[0] == '0)

endmodule

/* hdl/keypad_matrix_debounce_unit.sv */
// Top level of the 4x4 keypad matrix debounce unit: configuration registers,
// result register and handshakes. Depends on kmd_pkg, kmd_in_reg, kmd_core.
//
//   Channel  Handshake                Payload
//   in       in_valid_i / in_ready_o  row_index_i, column_bits_i
//   out      out_valid_o / out_ready_i key_down_vector_o
//   cfg      cfg_we_i                 cfg_index_i, cfg_data_i
//
// A row sample is registered in the input register, then updates the debounce
// state, and its key vector is registered for output on the same edge as the state.
// One transaction per cycle is sustained while the output is not stalled.
// Reset clears all press counters, key states and the idle counter and loads
// the default threshold and idle limit. A stalled output holds the input
// register, so at most two transactions are in flight.
module keypad_matrix_debounce_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  kmd_pkg::row_t                 row_index_i,
  input  kmd_pkg::col_t                 column_bits_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output kmd_pkg::key_vec_t             key_down_vector_o,
  input  logic                          cfg_we_i,
  input  logic [kmd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  kmd_pkg::cfg_t                 cfg_data_i
);
  import kmd_pkg::*;

  cfg_t     press_threshold_q;
  cfg_t     idle_limit_q;
  logic     out_valid_q, out_valid_d;
  key_vec_t out_vec_q;
  key_vec_t key_vec;
  sample_t  in_sample;
  sample_t  cur_sample;
  logic     cur_valid;
  logic     fire;

  assign in_sample.row  = row_index_i;
  assign in_sample.cols = column_bits_i;

  assign fire = cur_valid && (!out_valid_q || out_ready_i);

  kmd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .sample_i  (in_sample),
    .advance_i (fire),
    .valid_o   (cur_valid),
    .sample_o  (cur_sample)
  );

  kmd_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (fire),
    .sample_i          (cur_sample),
    .press_threshold_i (press_threshold_q),
    .idle_limit_i      (idle_limit_q),
    .key_vec_o         (key_vec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_threshold_q <= PRESS_THRESHOLD_RST;
      idle_limit_q      <= IDLE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PRESS_THRESHOLD: press_threshold_q <= cfg_data_i;
        CFG_IDLE_LIMIT:      idle_limit_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_d = fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_vec_q <= key_vec;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign key_down_vector_o = out_vec_q;

endmodule

/* dv/keypad_matrix_debounce_unit_test.sv */
// Self-checking testbench for keypad_matrix_debounce_unit: random and directed row samples
// checked against a debounce predictor held in a small scoreboard class.
// Depends on kmd_pkg and the keypad_matrix_debounce_unit RTL.
`timescale 1ns / 1ps

module keypad_matrix_debounce_unit_test;
  import kmd_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  class key_vector_scoreboard;
    count_t   presses[NUM_KEYS];
    key_vec_t keys_down;
    idle_t    idle_scans;
    cfg_t     threshold;
    cfg_t     idle_limit;
    key_vec_t expected_vectors[$];
    int       mismatches;

    function new();
      foreach (presses[i]) presses[i] = '0;
      keys_down  = '0;
      idle_scans = '0;
      threshold  = PRESS_THRESHOLD_RST;
      idle_limit = IDLE_LIMIT_RST;
      mismatches = 0;
    endfunction

    function void note_sample(row_t row, col_t cols);
      int k;
      if (cols != COLS_IDLE) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          k = int'(row) * NUM_COLS + NUM_COLS - 1 - c;
          if (cols[c]) begin
            keys_down[k] = 1'b0;
            presses[k] = '0;
          end else begin
            if (presses[k] != '1) presses[k] = presses[k] + 1'b1;
            if (presses[k] > threshold) keys_down = key_vec_t'(1) << k;
          end
        end
      end else begin
        idle_scans = idle_scans + 1'b1;
        if (idle_scans >= idle_limit) begin
          idle_scans = '0;
          keys_down = '0;
          foreach (presses[i]) presses[i] = '0;
        end
      end
      expected_vectors.push_back(keys_down);
    endfunction

    function void check_vector(key_vec_t got);
      key_vec_t want;
      if (expected_vectors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected key vector %h with nothing pending", got);
      end else begin
        want = expected_vectors.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("key vector mismatch: expected %h, got %h", want, got);
        end
      end
    endfunction

    function int pending();
      return expected_vectors.size();
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  row_t     row_index_i = '0;
  col_t     column_bits_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  key_vec_t key_down_vector_o;
  logic     cfg_we_i = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index_i = CFG_PRESS_THRESHOLD;
  cfg_t     cfg_data_i = '0;

  key_vector_scoreboard board;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  keypad_matrix_debounce_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .row_index_i      (row_index_i),
    .column_bits_i    (column_bits_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .key_down_vector_o(key_down_vector_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_vector(key_down_vector_o);
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("keypad_matrix_debounce_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input row_t row, input col_t cols);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    row_index_i   <= row;
    column_bits_i <= cols;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_sample(row, cols);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  task automatic write_config(input cfg_t threshold, input cfg_t limit);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_PRESS_THRESHOLD;
    cfg_data_i  <= threshold;
    @(posedge clk_i);
    board.threshold = threshold;
    cfg_index_i <= CFG_IDLE_LIMIT;
    cfg_data_i  <= limit;
    @(posedge clk_i);
    board.idle_limit = limit;
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input cfg_t threshold, input cfg_t limit, input int send_pct,
                           input int stall, input int item_target, input bit pressure);
    int   sent;
    int   n;
    int   pick;
    int   i;
    int   c;
    bit   long_hold;
    bit   sweep;
    key_vec_t held;
    row_t row;
    col_t cols;
    write_config(threshold, limit);
    send_idle_pct = send_pct;
    stall_pct = stall;
    sent = 0;
    while (sent < item_target) begin
      if (pressure && $urandom_range(15) == 0) drain();
      pick = $urandom_range(99);
      if (pick < 15) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_sample(row_t'($urandom_range(3)), col_t'($urandom_range(15)));
          sent++;
        end
      end else if (pick < 25) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          send_sample(row_t'($urandom_range(3)), COLS_IDLE);
          sent++;
        end
      end else begin
        long_hold = (threshold > 24) && ($urandom_range(1) == 0);
        held = key_vec_t'(1) << $urandom_range(NUM_KEYS - 1);
        if (!long_hold && $urandom_range(3) == 0) held |= key_vec_t'(1) << $urandom_range(15);
        sweep = !long_hold && ($urandom_range(1) == 1);
        if (long_hold) n = $urandom_range(250, 280);
        else if (threshold > 24) n = $urandom_range(1, 40);
        else n = $urandom_range(1, 4 * int'(threshold) + 12);
        for (i = 0; i < n; i++) begin
          if (sweep) row = row_t'(i);
          else do row = row_t'($urandom_range(3));
            while (held[int'(row) * NUM_COLS +: NUM_COLS] == '0);
          cols = '1;
          for (c = 0; c < NUM_COLS; c++) begin
            if (held[int'(row) * NUM_COLS + NUM_COLS - 1 - c]) cols[c] = 1'b0;
          end
          if (!long_hold && $urandom_range(19) == 0) cols[$urandom_range(3)] ^= 1'b1;
          send_sample(row, cols);
          sent++;
        end
      end
    end
  endtask

  initial begin
    board = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sample(2'd0, 4'b1111);
    send_sample(2'd3, 4'b0000);
    send_sample(2'd3, 4'b0000);
    send_sample(2'd1, 4'b1110);
    send_sample(2'd2, 4'b0111);
    send_sample(2'd0, 4'b1010);
    send_sample(2'd3, 4'b1111);
    send_sample(2'd2, 4'b1111);

    write_config(8'd0, 8'd0);
    send_sample(2'd2, 4'b0000);
    send_sample(2'd1, 4'b1010);
    send_sample(2'd0, 4'b1111);
    send_sample(2'd3, 4'b0111);
    send_sample(2'd3, 4'b1111);
    send_sample(2'd0, 4'b1110);
    send_sample(2'd0, 4'b0000);
    send_sample(2'd1, 4'b0001);
    send_sample(2'd0, 4'b1101);

    write_config(8'd255, 8'd1);
    send_sample(2'd2, 4'b0000);
    send_sample(2'd2, 4'b0000);
    send_sample(2'd2, 4'b1111);

    run_phase(8'd20, 8'd40, 0, 0, 250, 1'b0);
    run_phase(8'd3, 8'd5, 71, 0, 250, 1'b0);
    run_phase(8'd0, 8'd1, 0, 71, 200, 1'b0);
    run_phase(8'd254, 8'd255, 23, 23, 450, 1'b0);
    run_phase(8'd255, 8'd0, 0, 0, 150, 1'b0);
    run_phase(cfg_t'($urandom_range(12)), cfg_t'($urandom_range(1, 255)), 23, 23, 300, 1'b1);
    run_phase(8'd1, 8'd2, 0, 71, 150, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("keypad_matrix_debounce_unit test passed");
    end else begin
      $display("keypad_matrix_debounce_unit test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/kmd_pkg.sv
hdl/kmd_in_reg.sv
hdl/kmd_core.sv
hdl/keypad_matrix_debounce_unit.sv
dv/keypad_matrix_debounce_unit_test.sv
